/* design/snd_pkg.sv */
// Shared constants, types and helpers for the 2D simplex noise pipeline.
package snd_pkg;

  localparam int FB  = 16;
  localparam int IW  = 33 - FB;
  localparam int IJW = IW + 1;
  localparam int TW  = IJW + 31;
  localparam int DW  = 40;
  localparam int CW  = 48;

  localparam logic [30:0] F2_Q32 = 31'd1572067135;
  localparam logic [29:0] G2_Q32 = 30'd907633384;
  localparam logic signed [DW-1:0] ONE_Q32 = 40'sh01_0000_0000;
  localparam logic signed [DW-1:0] G2_D = 40'sd907633384;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [7:0]         gbyte;
  } corner_in_t;

  function automatic logic [3:0] mod12(input logic [7:0] v);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(v) * 16'd171;
    q = p[15:11];
    r = v - 8'((8'(q) << 3) + (8'(q) << 2));
    return r[3:0];
  endfunction

endpackage

/* design/snd_ram.sv */
// 256 x 8 hash table copy: one write port, one registered read port.
module snd_ram (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic       re,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/snd_corner.sv */
// One simplex corner: falloff, gradient select and contribution, five stages.
module snd_corner (
  input  logic                                clk,
  input  logic                                adv,
  input  snd_pkg::corner_in_t                 cin,
  output logic signed [snd_pkg::CW-1:0]       contrib
);
  import snd_pkg::*;

  logic              far_a_r;
  logic signed [24:0] dx_a_r, dy_a_r;
  logic [48:0]       sqx_a_r, sqy_a_r;
  logic [3:0]        g_a_r;
  logic              neg_b_r, neg_c_r, neg_d_r;
  logic [23:0]       t24_b_r;
  logic signed [25:0] dot_b_r, dot_c_r, dot_d_r;
  logic [22:0]       t2_c_r;
  logic [20:0]       t4_d_r;

  logic              fitx, fity;
  logic signed [49:0] sqx_full, sqy_full;
  logic signed [50:0] t48;
  logic signed [25:0] gxv, gyv;
  logic [47:0]       t24sq;
  logic [45:0]       t2sq;
  logic signed [47:0] prod;

  always_comb begin
    fitx     = (cin.dx[31:24] == {8{cin.dx[24]}});
    fity     = (cin.dy[31:24] == {8{cin.dy[24]}});
    sqx_full = $signed(cin.dx[24:0]) * $signed(cin.dx[24:0]);
    sqy_full = $signed(cin.dy[24:0]) * $signed(cin.dy[24:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      far_a_r <= !fitx || !fity;
      dx_a_r  <= $signed(cin.dx[24:0]);
      dy_a_r  <= $signed(cin.dy[24:0]);
      sqx_a_r <= sqx_full[48:0];
      sqy_a_r <= sqy_full[48:0];
      g_a_r   <= mod12(cin.gbyte);
    end
  end

  always_comb begin
    t48 = (51'sd1 <<< 47) - $signed({2'b00, sqx_a_r}) - $signed({2'b00, sqy_a_r});
    if (g_a_r < 4'd8) begin
      gxv = g_a_r[0] ? -26'(dx_a_r) : 26'(dx_a_r);
    end else begin
      gxv = '0;
    end
    if (g_a_r < 4'd4) begin
      gyv = g_a_r[1] ? -26'(dy_a_r) : 26'(dy_a_r);
    end else if (g_a_r < 4'd8) begin
      gyv = '0;
    end else begin
      gyv = g_a_r[0] ? -26'(dy_a_r) : 26'(dy_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_b_r <= far_a_r || t48[50];
      t24_b_r <= t48[47:24];
      dot_b_r <= gxv + gyv;
    end
  end

  assign t24sq = t24_b_r * t24_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_c_r  <= t24sq[46:24];
      neg_c_r <= neg_b_r;
      dot_c_r <= dot_b_r;
    end
  end

  assign t2sq = t2_c_r * t2_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_d_r  <= t2sq[44:24];
      neg_d_r <= neg_c_r;
      dot_d_r <= dot_c_r;
    end
  end

  assign prod = $signed({1'b0, t4_d_r}) * dot_d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      contrib <= neg_d_r ? '0 : prod;
    end
  end

endmodule

/* design/simplex_noise_2d.sv */
// Top level of the 2D simplex noise evaluator with its hash table memories.
// Usage:
//   Input stream in_*: in_tuser selects the operation (0 load, 1 evaluate).
//   A load writes one byte of the 256-entry hash table; an evaluation takes a
//   signed Q16.16 point and returns signed Q1.15 noise on out_*.
//   Every input transfer yields exactly one output transfer, in order; loads
//   return zero.
//   One item is taken per cycle unless the output stalls or an evaluation waits
//   behind a load; the pipeline is a 15-stage line ending in the output register.
//   The hash table is kept in five copies of a 256 x 8 memory with one read
//   port each (two for the row lookups, three for the corner lookups).
//   A load writes the copies when it reaches stage 6; an evaluation arriving
//   behind a load waits until that write is done, so table loads followed by
//   evaluations stall the input at the switch.
//   Table entries must be loaded before they are used for evaluation.
//   Reset clears all pipeline valid flags; table contents are kept.
//   When out_tready is low with a result pending, the whole pipeline holds
//   and in_tready drops.
module simplex_noise_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // op
  input  logic [79:0] in_tdata,   // table_index, table_value, x_coord, y_coord
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // noise_value
);
  import snd_pkg::*;

  localparam int NS = 15;

  logic          v_r [1:NS];
  op_t           op_r [1:NS];
  logic          adv, load_busy, wr_en;
  logic [7:0]    raddr [5];
  logic [7:0]    rq [5];

  logic signed [31:0]   x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r, x5_r, y5_r;
  logic signed [32:0]   sxy1_r;
  logic [7:0]           idx_r [1:6];
  logic [7:0]           val_r [1:6];
  logic signed [63:0]   prod2_r;
  logic signed [IW-1:0] i3_r, j3_r, i4_r, j4_r, i5_r, j5_r;
  logic signed [IJW-1:0] ij4_r;
  logic signed [TW-1:0] t32_5_r;
  logic [7:0]           ha5_r, hb5_r, ha6_r, hb6_r, ii6_r;
  logic signed [DW-1:0] x0_6_r, y0_6_r;
  logic signed [31:0]   dx7_r [3];
  logic signed [31:0]   dy7_r [3];
  logic signed [CW-1:0] contrib [3];
  logic signed [49:0]   sum13_r;
  logic signed [56:0]   m14_r;
  logic [15:0]          out15_r;

  logic signed [64:0]   prod_full;
  logic signed [32:0]   xs, ys;
  logic signed [TW-1:0] t32_full;
  logic signed [63:0]   x0_full, y0_full;
  logic                 i1;
  logic signed [DW-1:0] dxq [3];
  logic signed [DW-1:0] dyq [3];
  logic signed [56:0]   sum57;
  logic signed [57:0]   rnd;
  logic signed [24:0]   rs;
  logic [15:0]          sat;
  corner_in_t           cin [3];

  assign adv        = !v_r[NS] || out_tready;
  assign out_tvalid = v_r[NS];
  assign out_tdata  = out15_r;

  always_comb begin
    load_busy = 1'b0;
    for (int k = 1; k <= 6; k++) begin
      load_busy = load_busy || (v_r[k] && op_r[k] == OP_LOAD);
    end
  end

  assign in_tready = adv && !(in_tuser == OP_EVAL && load_busy);
  assign wr_en     = adv && v_r[6] && op_r[6] == OP_LOAD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NS; k++) begin
        v_r[k]  <= 1'b0;
        op_r[k] <= OP_LOAD;
      end
    end else if (adv) begin
      v_r[1]  <= in_tvalid && in_tready;
      op_r[1] <= op_t'(in_tuser);
      for (int k = 2; k <= NS; k++) begin
        v_r[k]  <= v_r[k-1];
        op_r[k] <= op_r[k-1];
      end
    end
  end

  // Front: skew, cell corner, unskew.
  assign prod_full = sxy1_r * $signed({1'b0, F2_Q32});
  assign xs        = 33'(x2_r) + 33'($signed(prod2_r[63:32]));
  assign ys        = 33'(y2_r) + 33'($signed(prod2_r[63:32]));
  assign t32_full  = ij4_r * $signed({1'b0, G2_Q32});
  assign x0_full   = (64'(x5_r) <<< (32 - FB)) - (64'(i5_r) <<< 32) + 64'(t32_5_r);
  assign y0_full   = (64'(y5_r) <<< (32 - FB)) - (64'(j5_r) <<< 32) + 64'(t32_5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= $signed(in_tdata[47:16]);
      y1_r    <= $signed(in_tdata[79:48]);
      sxy1_r  <= 33'($signed(in_tdata[47:16])) + 33'($signed(in_tdata[79:48]));
      idx_r[1] <= in_tdata[7:0];
      val_r[1] <= in_tdata[15:8];
      for (int k = 2; k <= 6; k++) begin
        idx_r[k] <= idx_r[k-1];
        val_r[k] <= val_r[k-1];
      end
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      prod2_r <= prod_full[63:0];
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      i3_r    <= $signed(xs[32:FB]);
      j3_r    <= $signed(ys[32:FB]);
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      i4_r    <= i3_r;
      j4_r    <= j3_r;
      ij4_r   <= IJW'(i3_r) + IJW'(j3_r);
      x5_r    <= x4_r;
      y5_r    <= y4_r;
      i5_r    <= i4_r;
      j5_r    <= j4_r;
      t32_5_r <= t32_full;
      ha5_r   <= rq[0];
      hb5_r   <= rq[1];
      x0_6_r  <= x0_full[DW-1:0];
      y0_6_r  <= y0_full[DW-1:0];
      ii6_r   <= i5_r[7:0];
      ha6_r   <= ha5_r;
      hb6_r   <= hb5_r;
    end
  end

  // Corner order, offsets and hash addresses.
  always_comb begin
    i1     = x0_6_r > y0_6_r;
    dxq[0] = x0_6_r;
    dyq[0] = y0_6_r;
    dxq[1] = x0_6_r - (i1 ? ONE_Q32 : '0) + G2_D;
    dyq[1] = y0_6_r - (i1 ? '0 : ONE_Q32) + G2_D;
    dxq[2] = x0_6_r - ONE_Q32 + (G2_D <<< 1);
    dyq[2] = y0_6_r - ONE_Q32 + (G2_D <<< 1);
    raddr[0] = j3_r[7:0];
    raddr[1] = j3_r[7:0] + 8'd1;
    raddr[2] = ii6_r + ha6_r;
    raddr[3] = ii6_r + 8'(i1) + (i1 ? ha6_r : hb6_r);
    raddr[4] = ii6_r + 8'd1 + hb6_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dx7_r[k] <= $signed(dxq[k][39:8]);
        dy7_r[k] <= $signed(dyq[k][39:8]);
      end
    end
  end

  for (genvar g = 0; g < 5; g++) begin : g_ram
    snd_ram u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (idx_r[6]),
      .wdata (val_r[6]),
      .re    (adv),
      .raddr (raddr[g]),
      .rdata (rq[g])
    );
  end

  for (genvar g = 0; g < 3; g++) begin : g_corner
    assign cin[g] = '{dx: dx7_r[g], dy: dy7_r[g], gbyte: rq[g+2]};
    snd_corner u_corner (
      .clk     (clk),
      .adv     (adv),
      .cin     (cin[g]),
      .contrib (contrib[g])
    );
  end

  // Sum, scale by 70, round and saturate.
  assign sum57 = 57'(sum13_r);
  assign rnd   = 58'(m14_r) + 58'sh1_0000_0000;
  assign rs    = $signed(rnd[57:33]);

  always_comb begin
    if (rs > 25'sd32767) begin
      sat = 16'h7fff;
    end else if (rs < -25'sd32768) begin
      sat = 16'h8000;
    end else begin
      sat = rs[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum13_r <= 50'(contrib[0]) + 50'(contrib[1]) + 50'(contrib[2]);
      m14_r   <= (sum57 <<< 6) + (sum57 <<< 2) + (sum57 <<< 1);
      out15_r <= (op_r[14] == OP_EVAL) ? sat : 16'h0000;
    end
  end

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && op_r[NS] == OP_LOAD |-> out_tdata == 16'h0000)
    else $error("load result not zero");

  a_no_eval_behind_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !((v_r[1] && op_r[1] == OP_EVAL) || (v_r[2] && op_r[2] == OP_EVAL) ||
                (v_r[3] && op_r[3] == OP_EVAL) || (v_r[4] && op_r[4] == OP_EVAL) ||
                (v_r[5] && op_r[5] == OP_EVAL)))
    else $error("evaluation passed a pending table write");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

endmodule
